// ----- hdl/crbf_pkg.sv -----
// ============================================================================
// Compact RBF package
// Shared order codes, derivative gains and pipeline latency of the compact
// radial basis function unit.
// ============================================================================
`default_nettype none

package crbf_pkg;

  typedef enum logic [1:0] {
    ORD0 = 2'd0,
    ORD1 = 2'd1,
    ORD2 = 2'd2,
    ORD3 = 2'd3
  } crbf_order_e;

  localparam logic [5:0] GAIN_ORD1 = 6'd20;
  localparam logic [5:0] GAIN_ORD2 = 6'd56;
  localparam logic [5:0] GAIN_ORD3 = 6'd22;

  localparam int unsigned LATENCY = 8;

endpackage

`default_nettype wire

// ----- hdl/crbf_poly.sv -----
// ============================================================================
// Compact RBF polynomial factors
// Forms the value factor, the first derivative factor and the magnitude and
// sign of the second derivative factor from r, r^2 and r^3.
// ============================================================================
`default_nettype none

module crbf_poly #(
  parameter int unsigned FRAC_BITS = 16,
  localparam int unsigned W = FRAC_BITS + 1,
  localparam int unsigned PW = FRAC_BITS + 8
) (
  input  crbf_pkg::crbf_order_e ord_i,
  input  logic [W-1:0]          m_i,
  input  logic [W-1:0]          r2_i,
  input  logic [W-1:0]          r3_i,
  output logic [PW-1:0]         pv_o,
  output logic [PW-1:0]         pd_o,
  output logic [PW-1:0]         pm_o,
  output logic                  pneg_o
);

  localparam int unsigned SW = FRAC_BITS + 10;
  localparam logic [SW-1:0] ONE_S = SW'(1) << FRAC_BITS;

  logic [SW-1:0] me;
  logic [SW-1:0] r2e;
  logic [SW-1:0] r3e;
  logic [SW-1:0] pv;
  logic [SW-1:0] pd;
  logic [SW-1:0] p;
  logic [SW-1:0] pmag;

  assign me  = SW'(m_i);
  assign r2e = SW'(r2_i);
  assign r3e = SW'(r3_i);

  always_comb begin
    case (ord_i)
      crbf_pkg::ORD1: begin
        pv = ONE_S + (me << 2);
        pd = ONE_S;
        p  = (me << 2) - ONE_S;
      end
      crbf_pkg::ORD2: begin
        pv = SW'(3) * ONE_S + SW'(18) * me + SW'(35) * r2e;
        pd = ONE_S + SW'(5) * me;
        p  = SW'(35) * r2e - (me << 2) - ONE_S;
      end
      crbf_pkg::ORD3: begin
        pv = ONE_S + (me << 3) + SW'(25) * r2e + (r3e << 5);
        pd = ONE_S + SW'(7) * me + (r2e << 4);
        p  = SW'(160) * r3e + SW'(15) * r2e - SW'(6) * me - ONE_S;
      end
      default: begin
        pv = ONE_S;
        pd = ONE_S;
        p  = ONE_S;
      end
    endcase
  end

  assign pneg_o = p[SW-1];
  assign pmag   = p[SW-1] ? (SW'(0) - p) : p;
  assign pm_o   = pmag[PW-1:0];
  assign pv_o   = pv[PW-1:0];
  assign pd_o   = pd[PW-1:0];

endmodule

`default_nettype wire

// ----- hdl/compact_rbf_value_and_derivatives_unit.sv -----
// A word taken on start gives its result with done_o high at the end of the pipeline.
// Throughput: one word per cycle; busy is never raised and the results cannot be held off.
// The latency is set by the eight register stages; every stage takes a new word each cycle.
// Reset clears the stage valid bits, done_o and the order register (order 0).
// ============================================================================
// Compact RBF value and derivatives unit
// Pipelined evaluation of the compactly supported radial basis function of
// the configured order, with its first and second radial derivatives.
// ============================================================================
`default_nettype none

module compact_rbf_value_and_derivatives_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_wdata_i,
  input  logic signed [17:0] distance_i,
  output logic               done_o,
  output logic [17:0]        basis_value_o,
  output logic signed [19:0] first_derivative_o,
  output logic signed [22:0] second_derivative_o
);

  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned W  = F + 1;
  localparam int unsigned PW = F + 8;
  localparam int unsigned EW = (F + 15 > 23) ? F + 15 : 23;
  localparam int unsigned CW = (F + 2 > 18) ? F + 2 : 18;
  localparam logic [CW-1:0] ONE_C = CW'(1) << F;
  localparam logic [EW-1:0] ONE_E = EW'(1) << F;

  crbf_pkg::crbf_order_e smoothness_order_q;
  logic [7:1]            vld_q;
  logic [7:1]            sup_q;
  crbf_pkg::crbf_order_e ord_q [1:7];
  logic                  done_q;

  logic [17:0]   m18;
  logic [CW-1:0] mc;
  logic          sup_d;
  logic [W-1:0]  m_s1_d;
  logic [W-1:0]  q_s1_d;

  logic [W-1:0] q_s1_q, m_s1_q;
  logic [W-1:0] q_s2_q, m_s2_q, qq2_s2_q, r2_s2_q;
  logic [W-1:0] q_s3_q, m_s3_q, qq2_s3_q, qq3_s3_q, qq4_s3_q, r2_s3_q, r3_s3_q;
  logic [W-1:0] q_s4_q, m_s4_q, qq2_s4_q, qq3_s4_q, qq4_s4_q, qq5_s4_q, qq6_s4_q, qq8_s4_q;
  logic [PW-1:0] pv_s4_q, pd_s4_q, pm_s4_q;
  logic          pneg_s4_q;
  logic [W-1:0]  q_s5_q, m_s5_q, qq3_s5_q, qq5_s5_q, qq7_s5_q;
  logic [PW-1:0] val_s5_q, ddm_s5_q, pd_s5_q;
  logic          pneg_s5_q;
  logic [W-1:0]  q_s6_q, mq_s6_q;
  logic [PW-1:0] val_s6_q, ddm_s6_q, pd_s6_q;
  logic          pneg_s6_q;
  logic [W-1:0]  q_s7_q;
  logic [PW-1:0] dm_s7_q, val_s7_q, ddm_s7_q;
  logic          pneg_s7_q;
  logic [17:0]   basis_value_q;
  logic [19:0]   first_derivative_q;
  logic [22:0]   second_derivative_q;

  logic [2*W-1:0]  qq2_prod, r2_prod, qq3_prod, qq4_prod, r3_prod;
  logic [2*W-1:0]  qq5_prod, qq6_prod, qq8_prod, qq7_prod, mq_prod;
  logic [PW+W-1:0] val_prod, ddm_prod, dm_prod;
  logic [PW-1:0]   pv_s4_d, pd_s4_d, pm_s4_d;
  logic            pneg_s4_d;
  logic [W-1:0]    qv_sel, qdd_sel, qd_sel;

  logic [5:0]    gain;
  logic [EW-1:0] dmag, ddmag;
  logic [EW-1:0] v_d, d_d, dd_d;

  assign busy = 1'b0;

  // Stage one: magnitude, support check and q = 1 - r.
  assign m18    = distance_i[17] ? (18'd0 - 18'(distance_i)) : 18'(distance_i);
  assign mc     = CW'(m18);
  assign sup_d  = (mc <= ONE_C);
  assign m_s1_d = W'(mc);
  assign q_s1_d = W'(ONE_C - mc);

  assign qq2_prod = q_s1_q * q_s1_q;
  assign r2_prod  = m_s1_q * m_s1_q;
  assign qq3_prod = qq2_s2_q * q_s2_q;
  assign qq4_prod = qq2_s2_q * qq2_s2_q;
  assign r3_prod  = r2_s2_q * m_s2_q;
  assign qq5_prod = qq4_s3_q * q_s3_q;
  assign qq6_prod = qq4_s3_q * qq2_s3_q;
  assign qq8_prod = qq4_s3_q * qq4_s3_q;
  assign qq7_prod = qq6_s4_q * q_s4_q;

  crbf_poly #(
    .FRAC_BITS(FRAC_BITS)
  ) u_poly (
    .ord_i (ord_q[3]),
    .m_i   (m_s3_q),
    .r2_i  (r2_s3_q),
    .r3_i  (r3_s3_q),
    .pv_o  (pv_s4_d),
    .pd_o  (pd_s4_d),
    .pm_o  (pm_s4_d),
    .pneg_o(pneg_s4_d)
  );

  always_comb begin
    case (ord_q[4])
      crbf_pkg::ORD1: begin
        qv_sel  = qq4_s4_q;
        qdd_sel = qq2_s4_q;
      end
      crbf_pkg::ORD2: begin
        qv_sel  = qq6_s4_q;
        qdd_sel = qq4_s4_q;
      end
      crbf_pkg::ORD3: begin
        qv_sel  = qq8_s4_q;
        qdd_sel = qq6_s4_q;
      end
      default: begin
        qv_sel  = qq2_s4_q;
        qdd_sel = qq2_s4_q;
      end
    endcase
  end

  assign val_prod = pv_s4_q * qv_sel;
  assign ddm_prod = pm_s4_q * qdd_sel;

  always_comb begin
    case (ord_q[5])
      crbf_pkg::ORD2: qd_sel = qq5_s5_q;
      crbf_pkg::ORD3: qd_sel = qq7_s5_q;
      default:        qd_sel = qq3_s5_q;
    endcase
  end

  assign mq_prod = m_s5_q * qd_sel;
  assign dm_prod = pd_s6_q * mq_s6_q;

  // Output stage: gain, sign and the order-zero and out-of-support cases.
  always_comb begin
    case (ord_q[7])
      crbf_pkg::ORD1: gain = crbf_pkg::GAIN_ORD1;
      crbf_pkg::ORD2: gain = crbf_pkg::GAIN_ORD2;
      default:        gain = crbf_pkg::GAIN_ORD3;
    endcase
  end

  assign dmag  = EW'(gain) * EW'(dm_s7_q);
  assign ddmag = EW'(gain) * EW'(ddm_s7_q);

  always_comb begin
    v_d  = EW'(val_s7_q);
    d_d  = EW'(0) - dmag;
    dd_d = pneg_s7_q ? (EW'(0) - ddmag) : ddmag;
    if (ord_q[7] == crbf_pkg::ORD0) begin
      d_d  = EW'(0) - (EW'(q_s7_q) << 1);
      dd_d = ONE_E << 1;
    end
    if (!sup_q[7]) begin
      v_d  = '0;
      d_d  = '0;
      dd_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smoothness_order_q <= crbf_pkg::ORD0;
      vld_q              <= '0;
      sup_q              <= '0;
      done_q             <= 1'b0;
      for (int i = 1; i <= 7; i++) begin
        ord_q[i] <= crbf_pkg::ORD0;
      end
    end else begin
      if (cfg_we_i) begin
        smoothness_order_q <= crbf_pkg::crbf_order_e'(cfg_wdata_i);
      end
      vld_q[1] <= start;
      sup_q[1] <= sup_d;
      ord_q[1] <= smoothness_order_q;
      for (int i = 2; i <= 7; i++) begin
        vld_q[i] <= vld_q[i-1];
        sup_q[i] <= sup_q[i-1];
        ord_q[i] <= ord_q[i-1];
      end
      done_q <= vld_q[7];
    end
  end

  always_ff @(posedge clk_i) begin
    q_s1_q <= q_s1_d;
    m_s1_q <= m_s1_d;

    q_s2_q   <= q_s1_q;
    m_s2_q   <= m_s1_q;
    qq2_s2_q <= qq2_prod[F +: W];
    r2_s2_q  <= r2_prod[F +: W];

    q_s3_q   <= q_s2_q;
    m_s3_q   <= m_s2_q;
    qq2_s3_q <= qq2_s2_q;
    qq3_s3_q <= qq3_prod[F +: W];
    qq4_s3_q <= qq4_prod[F +: W];
    r2_s3_q  <= r2_s2_q;
    r3_s3_q  <= r3_prod[F +: W];

    q_s4_q    <= q_s3_q;
    m_s4_q    <= m_s3_q;
    qq2_s4_q  <= qq2_s3_q;
    qq3_s4_q  <= qq3_s3_q;
    qq4_s4_q  <= qq4_s3_q;
    qq5_s4_q  <= qq5_prod[F +: W];
    qq6_s4_q  <= qq6_prod[F +: W];
    qq8_s4_q  <= qq8_prod[F +: W];
    pv_s4_q   <= pv_s4_d;
    pd_s4_q   <= pd_s4_d;
    pm_s4_q   <= pm_s4_d;
    pneg_s4_q <= pneg_s4_d;

    q_s5_q    <= q_s4_q;
    m_s5_q    <= m_s4_q;
    qq3_s5_q  <= qq3_s4_q;
    qq5_s5_q  <= qq5_s4_q;
    qq7_s5_q  <= qq7_prod[F +: W];
    val_s5_q  <= val_prod[F +: PW];
    ddm_s5_q  <= ddm_prod[F +: PW];
    pd_s5_q   <= pd_s4_q;
    pneg_s5_q <= pneg_s4_q;

    q_s6_q    <= q_s5_q;
    mq_s6_q   <= mq_prod[F +: W];
    val_s6_q  <= val_s5_q;
    ddm_s6_q  <= ddm_s5_q;
    pd_s6_q   <= pd_s5_q;
    pneg_s6_q <= pneg_s5_q;

    q_s7_q    <= q_s6_q;
    dm_s7_q   <= dm_prod[F +: PW];
    val_s7_q  <= val_s6_q;
    ddm_s7_q  <= ddm_s6_q;
    pneg_s7_q <= pneg_s6_q;

    basis_value_q       <= v_d[17:0];
    first_derivative_q  <= d_d[19:0];
    second_derivative_q <= dd_d[22:0];
  end

  assign done_o              = done_q;
  assign basis_value_o       = basis_value_q;
  assign first_derivative_o  = first_derivative_q;
  assign second_derivative_o = second_derivative_q;

endmodule

`default_nettype wire

// ----- hdl/crbf_checker.sv -----
// ============================================================================
// Compact RBF port checker
// Watches the ports of the unit for latency, stall-free operation and the
// zero results outside the support.
// ============================================================================
`default_nettype none

module crbf_checker #(
  parameter int unsigned FRAC_BITS = 16
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               done_o,
  input logic signed [17:0] distance_i,
  input logic [17:0]        basis_value_o,
  input logic signed [19:0] first_derivative_o,
  input logic signed [22:0] second_derivative_o
);

  localparam longint OneVal = longint'(1) << FRAC_BITS;

  logic far_word;

  assign far_word = (longint'(distance_i) > OneVal) || (longint'(distance_i) < -OneVal);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised although the pipeline never stalls");

  a_word_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##8 done_o)
    else $error("accepted word gave no result after the pipeline latency");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 8))
    else $error("result strobe without a word accepted one latency earlier");

  a_outside_support_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && far_word |-> ##8 (basis_value_o == '0 &&
      first_derivative_o == '0 && second_derivative_o == '0))
    else $error("word outside the support gave non-zero results");

endmodule

bind compact_rbf_value_and_derivatives_unit crbf_checker #(
  .FRAC_BITS(FRAC_BITS)
) u_crbf_checker (.*);

`default_nettype wire

// ----- tb/compact_rbf_value_and_derivatives_unit_tb.sv -----
// ============================================================================
// Compact RBF value and derivatives unit testbench
// Drives signed distances into the unit under every smoothness order and
// checks each result word, field by field, against a predictor of the
// compactly supported basis function and its two radial derivatives, or
// against the word typed into the table. A short table of directed words
// comes first, followed by random words with random gaps on the sending side.
// ============================================================================
`default_nettype none

module compact_rbf_value_and_derivatives_unit_tb;

  localparam int unsigned FRAC = 16;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_WORDS = 320;
  localparam int unsigned NUM_ROWS = 25;

  typedef struct packed {
    logic [17:0]        basis;
    logic signed [19:0] slope;
    logic signed [22:0] curvature;
  } rbf_word_t;

  typedef struct packed {
    crbf_pkg::crbf_order_e order;
    logic signed [17:0]    radius;
    logic                  typed;
    rbf_word_t             want;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic               cfg_we_i;
  logic [1:0]         cfg_wdata_i;
  logic signed [17:0] distance_i;
  logic               done_o;
  logic [17:0]        basis_value_o;
  logic signed [19:0] first_derivative_o;
  logic signed [22:0] second_derivative_o;

  rbf_word_t             pending_q[$];
  crbf_pkg::crbf_order_e model_order;
  crbf_pkg::crbf_order_e drive_order;
  logic                  row_typed;
  rbf_word_t             row_want;
  int unsigned           mismatches;
  int unsigned           cycle_count;
  stim_row_t             dir_table [NUM_ROWS];

  compact_rbf_value_and_derivatives_unit #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .distance_i          (distance_i),
    .done_o              (done_o),
    .basis_value_o       (basis_value_o),
    .first_derivative_o  (first_derivative_o),
    .second_derivative_o (second_derivative_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic longint frac_mul(input longint a, input longint b);
    return (a * b) >>> FRAC;
  endfunction

  function automatic rbf_word_t eval_rbf(input logic signed [17:0] radius,
                                         input crbf_pkg::crbf_order_e ord);
    longint one, m, q, q2, q3, q4, q5, q6, q7, q8, r2, r3;
    longint v, d, dd, p, pm;
    rbf_word_t res;
    one = longint'(1) << FRAC;
    m = (radius < 0) ? -longint'(radius) : longint'(radius);
    v = 0;
    d = 0;
    dd = 0;
    if (m <= one) begin
      q  = one - m;
      q2 = frac_mul(q, q);
      q3 = frac_mul(q2, q);
      q4 = frac_mul(q2, q2);
      q5 = frac_mul(q4, q);
      q6 = frac_mul(q4, q2);
      q7 = frac_mul(q6, q);
      q8 = frac_mul(q4, q4);
      r2 = frac_mul(m, m);
      r3 = frac_mul(r2, m);
      case (ord)
        crbf_pkg::ORD0: begin
          v  = q2;
          d  = -(2 * q);
          dd = 2 * one;
        end
        crbf_pkg::ORD1: begin
          v  = frac_mul(one + 4 * m, q4);
          d  = -(20 * frac_mul(m, q3));
          p  = 4 * m - one;
          pm = (p < 0) ? -p : p;
          dd = 20 * frac_mul(pm, q2);
          if (p < 0) dd = -dd;
        end
        crbf_pkg::ORD2: begin
          v  = frac_mul(3 * one + 18 * m + 35 * r2, q6);
          d  = -(56 * frac_mul(one + 5 * m, frac_mul(m, q5)));
          p  = 35 * r2 - 4 * m - one;
          pm = (p < 0) ? -p : p;
          dd = 56 * frac_mul(pm, q4);
          if (p < 0) dd = -dd;
        end
        default: begin
          v  = frac_mul(one + 8 * m + 25 * r2 + 32 * r3, q8);
          d  = -(22 * frac_mul(one + 7 * m + 16 * r2, frac_mul(m, q7)));
          p  = 160 * r3 + 15 * r2 - 6 * m - one;
          pm = (p < 0) ? -p : p;
          dd = 22 * frac_mul(pm, q6);
          if (p < 0) dd = -dd;
        end
      endcase
    end
    res.basis     = v[17:0];
    res.slope     = d[19:0];
    res.curvature = dd[22:0];
    return res;
  endfunction

  function automatic logic signed [17:0] rand_distance();
    logic signed [17:0] mag;
    case ($urandom_range(0, 9))
      0: return 18'($urandom);
      1: begin
        mag = 18'(65536 + $urandom_range(0, 4) - 2);
        return $urandom_range(0, 1) ? -mag : mag;
      end
      2: begin
        mag = 18'($urandom_range(0, 63));
        return $urandom_range(0, 1) ? mag : 18'(-131072 + mag);
      end
      default: begin
        mag = 18'($urandom_range(0, 65536));
        return $urandom_range(0, 1) ? -mag : mag;
      end
    endcase
  endfunction

  // Words are taken and results checked at the rising edge only.
  always @(posedge clk_i) begin
    rbf_word_t got, want;
    if (rst_ni) begin
      if (start && !busy) begin
        if (row_typed) pending_q.push_back(row_want);
        else pending_q.push_back(eval_rbf(distance_i, model_order));
      end
      if (cfg_we_i) model_order = crbf_pkg::crbf_order_e'(cfg_wdata_i);
      if (done_o) begin
        got.basis     = basis_value_o;
        got.slope     = first_derivative_o;
        got.curvature = second_derivative_o;
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("cycle %0d: result word with none pending: %0d %0d %0d",
                     cycle_count, got.basis, got.slope, got.curvature);
        end else begin
          want = pending_q.pop_front();
          if (got.basis !== want.basis || got.slope !== want.slope
              || got.curvature !== want.curvature) begin
            mismatches++;
            if (mismatches <= 10)
              $display("cycle %0d: expected %0d %0d %0d, got %0d %0d %0d",
                       cycle_count, want.basis, want.slope, want.curvature,
                       got.basis, got.slope, got.curvature);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic drive_word(input logic signed [17:0] radius, input logic typed,
                            input rbf_word_t want);
    @(negedge clk_i);
    start      <= 1'b1;
    distance_i <= radius;
    row_typed   = typed;
    row_want    = want;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start      <= 1'b0;
      distance_i <= 18'($urandom);
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_order(input crbf_pkg::crbf_order_e ord);
    drain_results();
    repeat (crbf_pkg::LATENCY) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ord;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    drive_order  = ord;
  endtask

  initial begin
    crbf_pkg::crbf_order_e phase_orders [6];
    rbf_word_t             none;
    none        = '0;
    phase_orders = '{crbf_pkg::ORD3, crbf_pkg::ORD0, crbf_pkg::ORD2, crbf_pkg::ORD1,
                     crbf_pkg::ORD3, crbf_pkg::ORD0};
    dir_table = '{
      '{crbf_pkg::ORD0, 18'sd0,       1'b1, '{18'd65536, -20'sd131072, 23'sd131072}},
      '{crbf_pkg::ORD0, 18'sd65536,   1'b1, '{18'd0, 20'sd0, 23'sd131072}},
      '{crbf_pkg::ORD0, -18'sd65536,  1'b1, '{18'd0, 20'sd0, 23'sd131072}},
      '{crbf_pkg::ORD0, 18'sd65537,   1'b1, '{18'd0, 20'sd0, 23'sd0}},
      '{crbf_pkg::ORD0, -18'sd131072, 1'b1, '{18'd0, 20'sd0, 23'sd0}},
      '{crbf_pkg::ORD0, 18'sd131071,  1'b1, '{18'd0, 20'sd0, 23'sd0}},
      '{crbf_pkg::ORD0, 18'sd1,       1'b0, '0},
      '{crbf_pkg::ORD0, -18'sd1,      1'b0, '0},
      '{crbf_pkg::ORD0, 18'sd32768,   1'b0, '0},
      '{crbf_pkg::ORD0, -18'sd21845,  1'b0, '0},
      '{crbf_pkg::ORD1, 18'sd0,       1'b1, '{18'd65536, 20'sd0, -23'sd1310720}},
      '{crbf_pkg::ORD1, 18'sd65536,   1'b1, '{18'd0, 20'sd0, 23'sd0}},
      '{crbf_pkg::ORD1, 18'sd16384,   1'b0, '0},
      '{crbf_pkg::ORD1, -18'sd40000,  1'b0, '0},
      '{crbf_pkg::ORD2, 18'sd0,       1'b1, '{18'd196608, 20'sd0, -23'sd3670016}},
      '{crbf_pkg::ORD2, -18'sd65536,  1'b1, '{18'd0, 20'sd0, 23'sd0}},
      '{crbf_pkg::ORD2, 18'sd12345,   1'b0, '0},
      '{crbf_pkg::ORD2, 18'sd50000,   1'b0, '0},
      '{crbf_pkg::ORD3, 18'sd0,       1'b1, '{18'd65536, 20'sd0, -23'sd1441792}},
      '{crbf_pkg::ORD3, 18'sd65536,   1'b1, '{18'd0, 20'sd0, 23'sd0}},
      '{crbf_pkg::ORD3, -18'sd1,      1'b0, '0},
      '{crbf_pkg::ORD3, 18'sd30000,   1'b0, '0},
      '{crbf_pkg::ORD3, -18'sd131071, 1'b1, '{18'd0, 20'sd0, 23'sd0}},
      '{crbf_pkg::ORD3, -18'sd65535,  1'b0, '0},
      '{crbf_pkg::ORD3, 18'sd100,     1'b0, '0}
    };
    rst_ni      = 1'b0;
    start       = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    distance_i  = '0;
    row_typed   = 1'b0;
    row_want    = '0;
    model_order = crbf_pkg::ORD0;
    drive_order = crbf_pkg::ORD0;
    mismatches  = 0;
    cycle_count = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_table[i]) begin
      if (dir_table[i].order != drive_order) set_order(dir_table[i].order);
      drive_word(dir_table[i].radius, dir_table[i].typed, dir_table[i].want);
    end

    foreach (phase_orders[ph]) begin
      set_order(phase_orders[ph]);
      for (int unsigned n = 0; n < PHASE_WORDS; n++) begin
        drive_word(rand_distance(), 1'b0, none);
        if (ph == 2 && n == PHASE_WORDS / 2) drain_results();
        else if (ph < 5 && $urandom_range(0, 7) == 0)
          idle_cycles($urandom_range(1, 16));
      end
    end

    drain_results();
    repeat (crbf_pkg::LATENCY + 4) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
hdl/crbf_pkg.sv
hdl/crbf_poly.sv
hdl/compact_rbf_value_and_derivatives_unit.sv
hdl/crbf_checker.sv
tb/compact_rbf_value_and_derivatives_unit_tb.sv
